// ----- hw/rtl/stct_pkg.sv -----
// Package with the types, constants and helper functions of the sphere-triangle contact test.
package stct_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int DOT_W = 68;
   localparam int MUL_W = 35;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W = 102;
   localparam int HALF_W = 34;
   localparam int QUO_W = COORD_W - 1;
   localparam int CNT_W = 5;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [QUO_W-1:0] MAG_LIM = {QUO_W{1'b1}};
   localparam logic [2:0] EDGE_ENABLE_MASK = 3'd7;
   localparam logic signed [DIFF_W-1:0] TOUCH_BOUND = DIFF_W'(1) <<< (FRAC_BITS + 8);

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_NORMAL = 2'd1;
   localparam logic [1:0] KIND_EVAL = 2'd2;

   localparam logic [1:0] PASS_FACE = 2'd0;
   localparam logic [1:0] PASS_EDGE = 2'd1;
   localparam logic [1:0] PASS_VERTEX = 2'd2;
   localparam logic [1:0] PASS_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] vertex_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [COORD_W-1:0] coord_y;
      logic [15:0] interaction_flags;
      logic [15:0] radius_sq;
      logic [1:0] test_pass;
   } req_type;

   typedef struct packed {
      logic hit;
      logic signed [COORD_W-1:0] contact_x;
      logic signed [COORD_W-1:0] contact_z;
      logic signed [COORD_W-1:0] contact_y;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SIDE, ST_SIDE_CHK, ST_NN, ST_NN_CHK, ST_MUL_HI, ST_MUL_LO,
      ST_SAT_CHK, ST_DIV, ST_ROUND, ST_TOUCH, ST_TOUCH_CHK, ST_BOX, ST_CROSS_A,
      ST_CROSS_B, ST_CROSS_CHK, ST_EDGE_SEL, ST_EE, ST_ED, ST_ED_CHK, ST_VTX_SEL,
      ST_DONE
   } st_type;

   typedef enum logic [2:0] {
      MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB, MAC_SHIFT
   } mac_op_type;

   function automatic logic [1:0] next_idx(input logic [1:0] i);
      return (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick3(
      input logic signed [COORD_W-1:0] a [3], input logic [1:0] s);
      logic signed [COORD_W-1:0] r;
      case (s)
         2'd1: r = a[1];
         2'd2: r = a[2];
         default: r = a[0];
      endcase
      return r;
   endfunction

   // Corner j needs its own flag bit and at least one flag bit of the mask that corner_mask gives for j.
   function automatic logic [2:0] corner_mask(input logic [1:0] j);
      logic [2:0] r;
      case (j)
         2'd1: r = 3'd2;
         2'd2: r = 3'd6;
         default: r = 3'd5;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [DIFF_W:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > (DIFF_W+1)'(COORD_MAX)) r = COORD_MAX;
      else if (v < (DIFF_W+1)'(COORD_MIN)) r = COORD_MIN;
      else r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

// ----- hw/rtl/sphere_triangle_contact_test.sv -----
// Top level of the sphere-triangle contact test: sequencer around one shared multiply-accumulate.
//
// Usage: a request beat is taken at a rising edge where start is high and busy is low.
// A load-vertex beat writes one triangle corner, a load-normal beat writes the normal and
// the 16-bit interaction flag word; both finish in the accepting cycle, busy stays low and
// no response follows. An evaluate beat carries the sphere centre, the squared radius and
// the pass. It raises busy until its single response beat, which stands on rsp_data for
// exactly one cycle marked by rsp_strobe; busy falls in the cycle after the strobe.
// The receiver cannot hold responses off, so no response is ever stalled or lost.
// Order of work: each dot product is accumulated axis by axis on the shared multiplier;
// each scaled coordinate takes a high and a low partial product, a saturation check, the
// restoring divider and a rounding step. A face pass scales every axis, an edge pass
// works through each enabled edge, a vertex pass checks each corner; misses exit early.
// The divider's one quotient bit per cycle sets the time of a face or edge pass.
// Reset clears the triangle, normal and flag word to zero and returns the sequencer to idle.
module sphere_triangle_contact_test
   import stct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   st_type state_ff, state_in;

   logic signed [COORD_W-1:0] vtx_ff [3][3];
   logic signed [COORD_W-1:0] vtx_in [3][3];
   logic signed [COORD_W-1:0] nrm_ff [3];
   logic signed [COORD_W-1:0] nrm_in [3];
   logic [15:0] flags_ff, flags_in;
   logic signed [COORD_W-1:0] ctr_ff [3];
   logic signed [COORD_W-1:0] ctr_in [3];
   logic [15:0] rad_ff, rad_in;
   logic [1:0] pass_ff, pass_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [DOT_W-1:0] num_ff, num_in;
   logic [DOT_W-1:0] den_ff, den_in;
   logic [DOT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] qsh_ff, qsh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] sel_ff, sel_in;
   logic far_ff, far_in;
   logic hit_ff, hit_in;
   logic signed [COORD_W-1:0] cp_ff [3];
   logic signed [COORD_W-1:0] cp_in [3];

   // Shared multiplier and its control.
   mac_op_type mac_op;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ACC_W-1:0] mul_ext;

   // Operand selection.
   logic signed [COORD_W-1:0] ck, nk, pk, qk, v0k, cpk;
   logic signed [COORD_W-1:0] pv [3];
   logic signed [COORD_W-1:0] qv [3];
   logic signed [COORD_W-1:0] v0 [3];
   logic signed [DIFF_W-1:0] e_k, w_k, wf_k, dd_k, m_k;
   logic [DIFF_W-1:0] mm;
   logic [DOT_W-1:0] num_mag;
   logic far_k;

   // Scaled ratio.
   logic sat;
   logic [DOT_W:0] rem2, rem2_diff;
   logic rem_ge, rnd;
   logic [QUO_W:0] q_round;
   logic [QUO_W-1:0] mag;
   logic signed [DIFF_W-1:0] off;
   logic signed [COORD_W-1:0] base_k, cp_new;

   // Point in triangle.
   logic [DIFF_W-1:0] an0, an1, an2;
   logic [1:0] ia, ib;
   logic rev;
   logic signed [COORD_W-1:0] va [3];
   logic signed [COORD_W-1:0] vb [3];
   logic signed [COORD_W-1:0] pa, pb, mina, maxa, minb, maxb;
   logic signed [COORD_W-1:0] vai, vaj, vbi, vbj;
   logic box_ok;

   // Decisions.
   logic side_neg, acc_zero, touch_ok, cross_pos, ed_skip, eval_go, vtx_ok;

   always_comb begin
      mul_p = mul_a * mul_b;
      mul_ext = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
   end

   // Operands drawn from the stores at the current axis and edge.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v0[k] = vtx_ff[0][k];
         case (sel_ff)
            2'd1: begin
               pv[k] = vtx_ff[1][k];
               qv[k] = vtx_ff[2][k];
            end
            2'd2: begin
               pv[k] = vtx_ff[2][k];
               qv[k] = vtx_ff[0][k];
            end
            default: begin
               pv[k] = vtx_ff[0][k];
               qv[k] = vtx_ff[1][k];
            end
         endcase
      end
      ck = pick3(ctr_ff, idx_ff);
      nk = pick3(nrm_ff, idx_ff);
      pk = pick3(pv, idx_ff);
      qk = pick3(qv, idx_ff);
      v0k = pick3(v0, idx_ff);
      cpk = pick3(cp_ff, idx_ff);
      e_k = DIFF_W'(qk) - DIFF_W'(pk);
      w_k = DIFF_W'(ck) - DIFF_W'(pk);
      wf_k = DIFF_W'(ck) - DIFF_W'(v0k);
      dd_k = DIFF_W'(cpk) - DIFF_W'(ck);
      far_k = (dd_k >= TOUCH_BOUND) || (dd_k <= -TOUCH_BOUND);
      m_k = (pass_ff == PASS_FACE) ? DIFF_W'(nk) : e_k;
      base_k = (pass_ff == PASS_FACE) ? ck : pk;
      mm = m_k[DIFF_W-1] ? DIFF_W'(-m_k) : DIFF_W'(m_k);
      num_mag = num_ff[DOT_W-1] ? DOT_W'(-num_ff) : DOT_W'(num_ff);
   end

   // Divider step, rounding and the clamped contact coordinate.
   always_comb begin
      sat = $unsigned(acc_ff) >= {3'b0, den_ff, {QUO_W{1'b0}}};
      rem2 = {rem_ff, qsh_ff[QUO_W-1]};
      rem2_diff = rem2 - {1'b0, den_ff};
      rem_ge = rem2 >= {1'b0, den_ff};
      rnd = {rem_ff, 1'b0} >= {1'b0, den_ff};
      q_round = {1'b0, qsh_ff} + (QUO_W+1)'(rnd);
      if (state_ff == ST_SAT_CHK || q_round[QUO_W]) mag = MAG_LIM;
      else mag = q_round[QUO_W-1:0];
      if (num_ff[DOT_W-1] ^ m_k[DIFF_W-1]) off = -{2'b0, mag};
      else off = {2'b0, mag};
      cp_new = clamp_coord((DIFF_W+1)'(base_k) + (DIFF_W+1)'(off));
   end

   // Dominant projection of the triangle and its bounding box.
   always_comb begin
      an0 = nrm_ff[0][COORD_W-1] ? DIFF_W'(-DIFF_W'(nrm_ff[0])) : DIFF_W'(nrm_ff[0]);
      an1 = nrm_ff[1][COORD_W-1] ? DIFF_W'(-DIFF_W'(nrm_ff[1])) : DIFF_W'(nrm_ff[1]);
      an2 = nrm_ff[2][COORD_W-1] ? DIFF_W'(-DIFF_W'(nrm_ff[2])) : DIFF_W'(nrm_ff[2]);
      if (an1 <= an0 && an0 > an2) begin
         ia = 2'd2;
         ib = 2'd1;
         rev = nrm_ff[0][COORD_W-1];
      end else if (an2 <= an1) begin
         ia = 2'd2;
         ib = 2'd0;
         rev = !nrm_ff[1][COORD_W-1];
      end else begin
         ia = 2'd0;
         ib = 2'd1;
         rev = !nrm_ff[2][COORD_W-1];
      end
      for (int i = 0; i < 3; i++) begin
         if (rev) begin
            va[i] = pick3(vtx_ff[2-i], ia);
            vb[i] = pick3(vtx_ff[2-i], ib);
         end else begin
            va[i] = pick3(vtx_ff[i], ia);
            vb[i] = pick3(vtx_ff[i], ib);
         end
      end
      pa = pick3(ctr_ff, ia);
      pb = pick3(ctr_ff, ib);
      mina = va[0];
      maxa = va[0];
      minb = vb[0];
      maxb = vb[0];
      for (int i = 1; i < 3; i++) begin
         if (va[i] < mina) mina = va[i];
         if (va[i] > maxa) maxa = va[i];
         if (vb[i] < minb) minb = vb[i];
         if (vb[i] > maxb) maxb = vb[i];
      end
      box_ok = (pa > mina) && (pa < maxa) && (pb > minb) && (pb < maxb);
      vai = pick3(va, idx_ff);
      vaj = pick3(va, next_idx(idx_ff));
      vbi = pick3(vb, idx_ff);
      vbj = pick3(vb, next_idx(idx_ff));
   end

   always_comb begin
      side_neg = acc_ff[ACC_W-1];
      acc_zero = (acc_ff == '0);
      touch_ok = !far_ff && ($unsigned(acc_ff) < {{(ACC_W-48){1'b0}}, rad_ff, 32'b0});
      cross_pos = !acc_ff[ACC_W-1] && !acc_zero;
      ed_skip = acc_ff[ACC_W-1] || ($unsigned(acc_ff[DOT_W-1:0]) > den_ff);
      eval_go = start && (req_data.kind == KIND_EVAL);
      vtx_ok = flags_ff[sel_ff] && ((flags_ff[2:0] & corner_mask(sel_ff)) != 3'b0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (eval_go) state_in = ST_SIDE;
         ST_SIDE: if (idx_ff == 2'd2) state_in = ST_SIDE_CHK;
         ST_SIDE_CHK: begin
            if (pass_ff == PASS_NONE || side_neg ||
                (pass_ff != PASS_FACE && (flags_ff[2:0] & EDGE_ENABLE_MASK) == 3'b0))
               state_in = ST_DONE;
            else if (pass_ff == PASS_FACE) state_in = ST_NN;
            else if (pass_ff == PASS_EDGE) state_in = ST_EDGE_SEL;
            else state_in = ST_VTX_SEL;
         end
         ST_NN: if (idx_ff == 2'd2) state_in = ST_NN_CHK;
         ST_NN_CHK: state_in = acc_zero ? ST_DONE : ST_MUL_HI;
         ST_MUL_HI: state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_SAT_CHK;
         ST_SAT_CHK: begin
            if (!sat) state_in = ST_DIV;
            else state_in = (idx_ff == 2'd2) ? ST_TOUCH : ST_MUL_HI;
         end
         ST_DIV: if (cnt_ff == CNT_W'(QUO_W - 1)) state_in = ST_ROUND;
         ST_ROUND: state_in = (idx_ff == 2'd2) ? ST_TOUCH : ST_MUL_HI;
         ST_TOUCH: if (idx_ff == 2'd2) state_in = ST_TOUCH_CHK;
         ST_TOUCH_CHK: begin
            if (pass_ff == PASS_FACE) state_in = touch_ok ? ST_BOX : ST_DONE;
            else if (touch_ok || sel_ff == 2'd2) state_in = ST_DONE;
            else state_in = (pass_ff == PASS_EDGE) ? ST_EDGE_SEL : ST_VTX_SEL;
         end
         ST_BOX: state_in = box_ok ? ST_CROSS_A : ST_DONE;
         ST_CROSS_A: state_in = ST_CROSS_B;
         ST_CROSS_B: state_in = ST_CROSS_CHK;
         ST_CROSS_CHK: begin
            if (cross_pos || idx_ff == 2'd2) state_in = ST_DONE;
            else state_in = ST_CROSS_A;
         end
         ST_EDGE_SEL: begin
            if (flags_ff[sel_ff]) state_in = ST_EE;
            else if (sel_ff == 2'd2) state_in = ST_DONE;
         end
         ST_EE: if (idx_ff == 2'd2) state_in = ST_ED;
         ST_ED: if (idx_ff == 2'd2) state_in = ST_ED_CHK;
         ST_ED_CHK: begin
            if (den_ff == '0) state_in = ST_TOUCH;
            else if (!ed_skip) state_in = ST_MUL_HI;
            else state_in = (sel_ff == 2'd2) ? ST_DONE : ST_EDGE_SEL;
         end
         ST_VTX_SEL: begin
            if (vtx_ok) state_in = ST_TOUCH;
            else if (sel_ff == 2'd2) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control for each state.
   always_comb begin
      vtx_in = vtx_ff;
      nrm_in = nrm_ff;
      flags_in = flags_ff;
      ctr_in = ctr_ff;
      rad_in = rad_ff;
      pass_in = pass_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      qsh_in = qsh_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      sel_in = sel_ff;
      far_in = far_ff;
      hit_in = hit_ff;
      cp_in = cp_ff;
      mac_op = MAC_HOLD;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.kind)
                  KIND_VERTEX: begin
                     if (req_data.vertex_index != 2'd3) begin
                        vtx_in[req_data.vertex_index[1:0]][0] = req_data.coord_x;
                        vtx_in[req_data.vertex_index[1:0]][1] = req_data.coord_z;
                        vtx_in[req_data.vertex_index[1:0]][2] = req_data.coord_y;
                     end
                  end
                  KIND_NORMAL: begin
                     nrm_in[0] = req_data.coord_x;
                     nrm_in[1] = req_data.coord_z;
                     nrm_in[2] = req_data.coord_y;
                     flags_in = req_data.interaction_flags;
                  end
                  KIND_EVAL: begin
                     ctr_in[0] = req_data.coord_x;
                     ctr_in[1] = req_data.coord_z;
                     ctr_in[2] = req_data.coord_y;
                     rad_in = req_data.radius_sq;
                     pass_in = req_data.test_pass;
                     idx_in = 2'd0;
                     hit_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SIDE: begin
            mac_op = (idx_ff == 2'd0) ? MAC_LOAD : MAC_ADD;
            mul_a = MUL_W'(nk);
            mul_b = MUL_W'(wf_k);
            idx_in = next_idx(idx_ff);
         end
         ST_SIDE_CHK: begin
            num_in = -acc_ff[DOT_W-1:0];
            idx_in = 2'd0;
            sel_in = 2'd0;
         end
         ST_NN: begin
            mac_op = (idx_ff == 2'd0) ? MAC_LOAD : MAC_ADD;
            mul_a = MUL_W'(nk);
            mul_b = MUL_W'(nk);
            idx_in = next_idx(idx_ff);
         end
         ST_NN_CHK: begin
            den_in = acc_ff[DOT_W-1:0];
            idx_in = 2'd0;
         end
         ST_MUL_HI: begin
            mac_op = MAC_LOAD;
            mul_a = {1'b0, num_mag[DOT_W-1:HALF_W]};
            mul_b = {2'b0, mm};
         end
         ST_MUL_LO: begin
            mac_op = MAC_SHIFT;
            mul_a = {1'b0, num_mag[HALF_W-1:0]};
            mul_b = {2'b0, mm};
         end
         ST_SAT_CHK: begin
            if (sat) begin
               cp_in[idx_ff] = cp_new;
               idx_in = next_idx(idx_ff);
            end else begin
               rem_in = acc_ff[QUO_W+DOT_W-1:QUO_W];
               qsh_in = acc_ff[QUO_W-1:0];
               cnt_in = '0;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem2_diff[DOT_W-1:0] : rem2[DOT_W-1:0];
            qsh_in = {qsh_ff[QUO_W-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_ROUND: begin
            cp_in[idx_ff] = cp_new;
            idx_in = next_idx(idx_ff);
         end
         ST_TOUCH: begin
            mac_op = (idx_ff == 2'd0) ? MAC_LOAD : MAC_ADD;
            mul_a = MUL_W'(dd_k);
            mul_b = MUL_W'(dd_k);
            far_in = ((idx_ff == 2'd0) ? 1'b0 : far_ff) | far_k;
            idx_in = next_idx(idx_ff);
         end
         ST_TOUCH_CHK: begin
            idx_in = 2'd0;
            if (pass_ff != PASS_FACE) begin
               if (touch_ok) hit_in = 1'b1;
               else sel_in = next_idx(sel_ff);
            end
         end
         ST_BOX: idx_in = 2'd0;
         ST_CROSS_A: begin
            mac_op = MAC_LOAD;
            mul_a = MUL_W'(DIFF_W'(vaj) - DIFF_W'(vai));
            mul_b = MUL_W'(DIFF_W'(pb) - DIFF_W'(vbi));
         end
         ST_CROSS_B: begin
            mac_op = MAC_SUB;
            mul_a = MUL_W'(DIFF_W'(vbj) - DIFF_W'(vbi));
            mul_b = MUL_W'(DIFF_W'(pa) - DIFF_W'(vai));
         end
         ST_CROSS_CHK: begin
            if (!cross_pos && idx_ff == 2'd2) hit_in = 1'b1;
            idx_in = next_idx(idx_ff);
         end
         ST_EDGE_SEL: begin
            idx_in = 2'd0;
            if (!flags_ff[sel_ff]) sel_in = next_idx(sel_ff);
         end
         ST_EE: begin
            mac_op = (idx_ff == 2'd0) ? MAC_LOAD : MAC_ADD;
            mul_a = MUL_W'(e_k);
            mul_b = MUL_W'(e_k);
            idx_in = next_idx(idx_ff);
         end
         ST_ED: begin
            mac_op = (idx_ff == 2'd0) ? MAC_LOAD : MAC_ADD;
            mul_a = MUL_W'(e_k);
            mul_b = MUL_W'(w_k);
            if (idx_ff == 2'd0) den_in = acc_ff[DOT_W-1:0];
            idx_in = next_idx(idx_ff);
         end
         ST_ED_CHK: begin
            num_in = acc_ff[DOT_W-1:0];
            idx_in = 2'd0;
            if (den_ff == '0) cp_in = pv;
            else if (ed_skip) sel_in = next_idx(sel_ff);
         end
         ST_VTX_SEL: begin
            idx_in = 2'd0;
            if (vtx_ok) cp_in = pv;
            else sel_in = next_idx(sel_ff);
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      case (mac_op)
         MAC_LOAD: acc_in = mul_ext;
         MAC_ADD: acc_in = acc_ff + mul_ext;
         MAC_SUB: acc_in = acc_ff - mul_ext;
         MAC_SHIFT: acc_in = (acc_ff <<< HALF_W) + mul_ext;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) vtx_ff[v][k] <= '0;
            nrm_ff[v] <= '0;
         end
         flags_ff <= '0;
         hit_ff <= 1'b0;
         idx_ff <= '0;
         sel_ff <= '0;
         cnt_ff <= '0;
         far_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vtx_ff <= vtx_in;
         nrm_ff <= nrm_in;
         flags_ff <= flags_in;
         hit_ff <= hit_in;
         idx_ff <= idx_in;
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
         far_ff <= far_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      rad_ff <= rad_in;
      pass_ff <= pass_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
      cp_ff <= cp_in;
   end

   // The response beat shows the contact point only on a hit.
   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_data.hit = hit_ff;
   assign rsp_data.contact_x = hit_ff ? cp_ff[0] : '0;
   assign rsp_data.contact_z = hit_ff ? cp_ff[1] : '0;
   assign rsp_data.contact_y = hit_ff ? cp_ff[2] : '0;

   // An accepted evaluate beat always makes the block busy in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_EVAL) |=> busy)
      else $error("evaluate beat did not start the sequencer");

   // Load beats never produce a response.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind != KIND_EVAL) |=> !rsp_strobe)
      else $error("load beat produced a response");

   // One response per evaluate: the strobe is followed by idle.
   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("sequencer stayed busy after the response beat");

   // The divider runs only on a nonzero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("divider started with a zero denominator");

endmodule
